// ===== sv/lbr_pkg.sv =====
// shared types and constants of the letterbox bilinear resampler
`timescale 1ns / 1ps
package lbr_pkg;

   localparam int MAX_SRC_WIDTH_DEF  = 1024;
   localparam int MAX_SRC_HEIGHT_DEF = 1024;

   localparam int CFG_WIDTH   = 11;
   localparam int SCALE_WIDTH = 27;
   localparam int POS_WIDTH   = 10;
   localparam int CH_WIDTH    = 8;
   localparam int PIX_WIDTH   = 24;
   localparam int OUT_WIDTH   = 16;
   localparam int PROD_WIDTH  = 38;
   localparam int ADDR_WIDTH  = 5;

   localparam logic [OUT_WIDTH-1:0] PAD_Q8 = 16'd29184;

   localparam logic CMD_STORE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [2:0] REG_SRC_W = 3'd0;
   localparam logic [2:0] REG_SRC_H = 3'd1;
   localparam logic [2:0] REG_TGT_W = 3'd2;
   localparam logic [2:0] REG_TGT_H = 3'd3;
   localparam logic [2:0] REG_RSZ_W = 3'd4;
   localparam logic [2:0] REG_RSZ_H = 3'd5;
   localparam logic [2:0] REG_SCALE = 3'd6;

   typedef struct packed {
      logic       x0_odd;
      logic       x1_odd;
      logic       y0_odd;
      logic       y1_odd;
      logic [7:0] wx;
      logic [7:0] wy;
      logic       pad;
   } lbr_tap_type;

endpackage

// ===== sv/lbr_bank_ram.sv =====
// one bank of the frame store, registered read
`timescale 1ns / 1ps
module lbr_bank_ram #(
   parameter int DEPTH = 4,
   parameter int AW    = 2
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic                        we,
   input  logic [AW-1:0]               waddr,
   input  logic [lbr_pkg::PIX_WIDTH-1:0] wdata,
   input  logic [AW-1:0]               raddr,
   output logic [lbr_pkg::PIX_WIDTH-1:0] rdata
);
   import lbr_pkg::*;

   logic [PIX_WIDTH-1:0] mem [DEPTH];
   logic [PIX_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[waddr] <= wdata;
         end
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/lbr_axis_map.sv =====
// maps a destination coordinate to two source cells and a weight
`timescale 1ns / 1ps
module lbr_axis_map #(
   parameter int MAX_SIZE = 1024,
   parameter int CW       = 10
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [lbr_pkg::POS_WIDTH-1:0]   d,
   input  logic [lbr_pkg::SCALE_WIDTH-1:0] scale,
   input  logic [lbr_pkg::CFG_WIDTH-1:0]   size_cfg,
   output logic [CW-1:0]                 p0,
   output logic [CW-1:0]                 p1,
   output logic [7:0]                    w
);
   import lbr_pkg::*;

   localparam int NW = CW + 1;
   localparam int SW = CW + 16;

   logic [PROD_WIDTH-1:0] prod_in, prod_ff;
   logic [SW-1:0]         src_in, src_ff;
   logic [NW-1:0]         n;
   logic [CW-1:0]         nm1;
   logic [PROD_WIDTH-2:0] half, sub;
   logic [SW-1:0]         top;

   assign prod_in = PROD_WIDTH'({d, 1'b1}) * PROD_WIDTH'(scale);

   always_comb begin
      if (size_cfg == '0) begin
         n = NW'(1);
      end else if (32'(size_cfg) > MAX_SIZE) begin
         n = NW'(MAX_SIZE);
      end else begin
         n = NW'(size_cfg);
      end
   end

   assign nm1  = CW'(n - NW'(1));
   assign top  = {nm1, 16'd0};
   assign half = prod_ff[PROD_WIDTH-1:1];
   assign sub  = half - (PROD_WIDTH-1)'(32768);

   always_comb begin
      if (half < (PROD_WIDTH-1)'(32768)) begin
         src_in = '0;
      end else if (sub > (PROD_WIDTH-1)'(top)) begin
         src_in = top;
      end else begin
         src_in = sub[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         src_ff  <= src_in;
      end
   end

   assign p0 = src_ff[SW-1:16];
   assign p1 = (p0 == nm1) ? p0 : p0 + CW'(1);
   assign w  = src_ff[15:8];

endmodule

// ===== sv/lbr_blend.sv =====
// bilinear blend of four neighbours, horizontal stage registered
`timescale 1ns / 1ps
module lbr_blend (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [3:0][lbr_pkg::PIX_WIDTH-1:0]   bank_data,
   input  lbr_pkg::lbr_tap_type                 tap,
   output logic [2:0][lbr_pkg::OUT_WIDTH-1:0]   chan
);
   import lbr_pkg::*;

   logic [PIX_WIDTH-1:0]      p00, p10, p01, p11;
   logic [8:0]                wxi, wyi;
   logic [2:0][15:0]          hi_in, lo_in, hi_ff, lo_ff;
   logic [7:0]                wy_ff;
   logic                      pad_ff;
   logic [2:0][23:0]          v;

   assign p00 = bank_data[{tap.y0_odd, tap.x0_odd}];
   assign p10 = bank_data[{tap.y0_odd, tap.x1_odd}];
   assign p01 = bank_data[{tap.y1_odd, tap.x0_odd}];
   assign p11 = bank_data[{tap.y1_odd, tap.x1_odd}];
   assign wxi = 9'd256 - 9'(tap.wx);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         hi_in[c] = 16'(17'(p00[c*8 +: 8]) * 17'(wxi) + 17'(p10[c*8 +: 8]) * 17'(tap.wx));
         lo_in[c] = 16'(17'(p01[c*8 +: 8]) * 17'(wxi) + 17'(p11[c*8 +: 8]) * 17'(tap.wx));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         wy_ff  <= tap.wy;
         pad_ff <= tap.pad;
      end
   end

   assign wyi = 9'd256 - 9'(wy_ff);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         v[c] = 24'(25'(hi_ff[c]) * 25'(wyi) + 25'(lo_ff[c]) * 25'(wy_ff));
         if (pad_ff) begin
            chan[c] = PAD_Q8;
         end else begin
            chan[c] = 16'((25'(v[c]) + 25'd128) >> 8);
         end
      end
   end

endmodule

// ===== sv/letterbox_bilinear_resampler_unit.sv =====
// letterbox bilinear resampler top level: registers, banked frame store, pipeline
// a sample item passes stages s1 to s4 and then the result register before it is shown
// throughput: one item per cycle unless held, stores and samples alike; four banks by row and
// column parity serve the four neighbour reads of a sample in one cycle
// the whole pipeline holds while the result register is full and not taken
// reset clears control and loads the registers with defaults; the frame store is undefined until written
`timescale 1ns / 1ps
module letterbox_bilinear_resampler_unit #(
   parameter int MAX_SRC_WIDTH  = lbr_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = lbr_pkg::MAX_SRC_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [lbr_pkg::POS_WIDTH-1:0]     req_pos_x,
   input  logic [lbr_pkg::POS_WIDTH-1:0]     req_pos_y,
   input  logic [lbr_pkg::CH_WIDTH-1:0]      req_red_in,
   input  logic [lbr_pkg::CH_WIDTH-1:0]      req_green_in,
   input  logic [lbr_pkg::CH_WIDTH-1:0]      req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lbr_pkg::POS_WIDTH-1:0]     rsp_out_col,
   output logic [lbr_pkg::POS_WIDTH-1:0]     rsp_out_row,
   output logic [lbr_pkg::OUT_WIDTH-1:0]     rsp_red_out,
   output logic [lbr_pkg::OUT_WIDTH-1:0]     rsp_green_out,
   output logic [lbr_pkg::OUT_WIDTH-1:0]     rsp_blue_out,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lbr_pkg::ADDR_WIDTH-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import lbr_pkg::*;

   localparam int XW    = $clog2(MAX_SRC_WIDTH);
   localparam int YW    = $clog2(MAX_SRC_HEIGHT);
   localparam int HW    = (MAX_SRC_WIDTH + 1) / 2;
   localparam int HH    = (MAX_SRC_HEIGHT + 1) / 2;
   localparam int DEPTH = HW * HH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CFG_WIDTH-1:0]   src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff, rsz_w_ff, rsz_h_ff;
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic                   csr_wr;

   logic adv, acc;
   logic pad_in, inr_in;

   logic                 s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic                 s1_cmd_ff, s2_cmd_ff, s3_cmd_ff, s4_cmd_ff;
   logic [POS_WIDTH-1:0] s1_x_ff, s2_x_ff, s3_x_ff, s4_x_ff;
   logic [POS_WIDTH-1:0] s1_y_ff, s2_y_ff, s3_y_ff, s4_y_ff;
   logic [PIX_WIDTH-1:0] s1_rgb_ff, s2_rgb_ff;
   logic                 s1_pad_ff, s2_pad_ff;
   logic                 s1_inr_ff, s2_inr_ff;
   lbr_tap_type          tap_in, s3_tap_ff;

   logic [XW-1:0] x0, x1, sx;
   logic [YW-1:0] y0, y1, sy;
   logic [7:0]    wx, wy;
   logic [1:0][XW-1:0] xsel;
   logic [1:0][YW-1:0] ysel;
   logic [AW-1:0]      waddr;
   logic [3:0][AW-1:0] raddr;
   logic [3:0]         bank_we;
   logic [3:0][PIX_WIDTH-1:0] bank_data;
   logic [2:0][OUT_WIDTH-1:0] chan;

   logic                 rsp_valid_ff;
   logic [POS_WIDTH-1:0] col_ff, row_ff;
   logic [2:0][OUT_WIDTH-1:0] chan_ff;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 11'd1024;
         src_h_ff <= 11'd1024;
         tgt_w_ff <= 11'd416;
         tgt_h_ff <= 11'd416;
         rsz_w_ff <= 11'd416;
         rsz_h_ff <= 11'd416;
         scale_ff <= 27'd65536;
      end else if (csr_wr) begin
         case (paddr[4:2])
            REG_SRC_W: src_w_ff <= pwdata[CFG_WIDTH-1:0];
            REG_SRC_H: src_h_ff <= pwdata[CFG_WIDTH-1:0];
            REG_TGT_W: tgt_w_ff <= pwdata[CFG_WIDTH-1:0];
            REG_TGT_H: tgt_h_ff <= pwdata[CFG_WIDTH-1:0];
            REG_RSZ_W: rsz_w_ff <= pwdata[CFG_WIDTH-1:0];
            REG_RSZ_H: rsz_h_ff <= pwdata[CFG_WIDTH-1:0];
            REG_SCALE: scale_ff <= pwdata[SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_SRC_W: prdata = 32'(src_w_ff);
         REG_SRC_H: prdata = 32'(src_h_ff);
         REG_TGT_W: prdata = 32'(tgt_w_ff);
         REG_TGT_H: prdata = 32'(tgt_h_ff);
         REG_RSZ_W: prdata = 32'(rsz_w_ff);
         REG_RSZ_H: prdata = 32'(rsz_h_ff);
         REG_SCALE: prdata = 32'(scale_ff);
         default:   prdata = '0;
      endcase
   end

   // pipeline control
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign acc       = req_valid && adv;

   assign pad_in = ({1'b0, req_pos_x} >= rsz_w_ff) || ({1'b0, req_pos_x} >= tgt_w_ff) ||
                   ({1'b0, req_pos_y} >= rsz_h_ff) || ({1'b0, req_pos_y} >= tgt_h_ff);
   assign inr_in = (32'(req_pos_x) < MAX_SRC_WIDTH) && (32'(req_pos_y) < MAX_SRC_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= acc;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         rsp_valid_ff <= s4_vld_ff && (s4_cmd_ff == CMD_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff <= req_command;
         s1_x_ff   <= req_pos_x;
         s1_y_ff   <= req_pos_y;
         s1_rgb_ff <= {req_blue_in, req_green_in, req_red_in};
         s1_pad_ff <= pad_in;
         s1_inr_ff <= inr_in;
         s2_cmd_ff <= s1_cmd_ff;
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_rgb_ff <= s1_rgb_ff;
         s2_pad_ff <= s1_pad_ff;
         s2_inr_ff <= s1_inr_ff;
         s3_cmd_ff <= s2_cmd_ff;
         s3_x_ff   <= s2_x_ff;
         s3_y_ff   <= s2_y_ff;
         s3_tap_ff <= tap_in;
         s4_cmd_ff <= s3_cmd_ff;
         s4_x_ff   <= s3_x_ff;
         s4_y_ff   <= s3_y_ff;
         col_ff    <= s4_x_ff;
         row_ff    <= s4_y_ff;
         chan_ff   <= chan;
      end
   end

   // coordinate mapping, one unit per axis
   lbr_axis_map #(.MAX_SIZE(MAX_SRC_WIDTH), .CW(XW)) u_map_x (
      .clock(clock), .en(adv), .d(req_pos_x), .scale(scale_ff),
      .size_cfg(src_w_ff), .p0(x0), .p1(x1), .w(wx)
   );

   lbr_axis_map #(.MAX_SIZE(MAX_SRC_HEIGHT), .CW(YW)) u_map_y (
      .clock(clock), .en(adv), .d(req_pos_y), .scale(scale_ff),
      .size_cfg(src_h_ff), .p0(y0), .p1(y1), .w(wy)
   );

   assign tap_in = '{x0_odd: x0[0], x1_odd: x1[0], y0_odd: y0[0], y1_odd: y1[0],
                     wx: wx, wy: wy, pad: s2_pad_ff};

   // banked frame store, bank index is {row parity, column parity}
   assign sx = XW'(s2_x_ff);
   assign sy = YW'(s2_y_ff);
   assign waddr = AW'(AW'(sy >> 1) * AW'(HW) + AW'(sx >> 1));

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         xsel[b] = (x0[0] == b[0]) ? x0 : x1;
         ysel[b] = (y0[0] == b[0]) ? y0 : y1;
      end
      for (int k = 0; k < 4; k++) begin
         raddr[k]   = AW'(AW'(ysel[k/2] >> 1) * AW'(HW) + AW'(xsel[k%2] >> 1));
         bank_we[k] = s2_vld_ff && (s2_cmd_ff == CMD_STORE) && s2_inr_ff &&
                      ({sy[0], sx[0]} == k[1:0]);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      lbr_bank_ram #(.DEPTH(DEPTH), .AW(AW)) u_bank (
         .clock(clock), .en(adv), .we(bank_we[g]), .waddr(waddr),
         .wdata(s2_rgb_ff), .raddr(raddr[g]), .rdata(bank_data[g])
      );
   end

   lbr_blend u_blend (
      .clock(clock), .en(adv), .bank_data(bank_data), .tap(s3_tap_ff), .chan(chan)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_red_out   = chan_ff[0];
   assign rsp_green_out = chan_ff[1];
   assign rsp_blue_out  = chan_ff[2];

`ifndef NO_ASSERTIONS
   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we)) else $error("store writes more than one bank");

   a_sample_gives_item: assert property (@(posedge clock) disable iff (reset)
      (adv && s4_vld_ff && s4_cmd_ff == CMD_SAMPLE) |=> rsp_valid)
      else $error("sample item lost at output");

   a_store_no_item: assert property (@(posedge clock) disable iff (reset)
      (adv && !(s4_vld_ff && s4_cmd_ff == CMD_SAMPLE)) |=> !rsp_valid)
      else $error("output item without a sample");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!adv && s2_vld_ff) |=> s2_vld_ff && $stable(s2_x_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
